### rtl/fufe_pkg.sv
// Shared types, codes and byte constants for the form field extractor.
// No dependencies; used by fufe_step, fufe_queue and the top level.
package fufe_pkg;

    localparam logic [1:0] PH_NAME  = 2'd0;
    localparam logic [1:0] PH_SKIP  = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [1:0] KIND_VALUE     = 2'd0;
    localparam logic [1:0] KIND_FOUND     = 2'd1;
    localparam logic [1:0] KIND_NOT_FOUND = 2'd2;

    localparam logic [2:0] REG_KEY_LENGTH  = 3'd0;
    localparam logic [2:0] REG_KEY_LOW     = 3'd1;
    localparam logic [2:0] REG_KEY_HIGH    = 3'd2;
    localparam logic [2:0] REG_VALUE_LIMIT = 3'd3;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF_HEX  = 8'h66;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF_HEX  = 8'h46;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int MAX_PUSH    = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0]          count;
        result_t [MAX_PUSH-1:0] items;
    } push_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [4:0] name_len;
        logic       name_match;
        logic [1:0] esc;
        logic [7:0] hex1;
        logic [7:0] emitted;
    } parse_state_t;

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c inside {[CH_0:CH_9]}) begin
            r = {1'b1, 4'(c - CH_0)};
        end
        else if (c inside {[CH_LA:CH_LF_HEX]}) begin
            r = {1'b1, 4'(c - CH_LA + 8'd10)};
        end
        else if (c inside {[CH_UA:CH_UF_HEX]}) begin
            r = {1'b1, 4'(c - CH_UA + 8'd10)};
        end
        return r;
    endfunction

    function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] ha;
        logic [4:0] hb;
        logic [7:0] r;
        ha = hex_nibble(a);
        hb = hex_nibble(b);
        r  = '0;
        if (ha[4]) begin
            r = hb[4] ? {ha[3:0], hb[3:0]} : {4'b0, ha[3:0]};
        end
        else if (a == CH_SPACE || a inside {[CH_TAB:CH_CR]} || a == CH_PLUS) begin
            r = hb[4] ? {4'b0, hb[3:0]} : 8'd0;
        end
        else if (a == CH_MINUS && hb[4]) begin
            r = 8'd0 - {4'b0, hb[3:0]};
        end
        return r;
    endfunction

endpackage

### rtl/form_urlencoded_field_extract.sv
// Top level of the form field extractor: configuration registers, parse state,
// step logic and result queue. Depends on fufe_pkg, fufe_step and fufe_queue.
//
// Accepts one body byte per clock and returns its results through a four-entry
// queue, one result beat per clock while out_ready is high. A byte yields up to
// three results (value bytes, then the status item), so in_ready drops while
// fewer than three queue slots are free; with out_ready held high, bytes that
// each give at most one result stream at one per cycle, and the output port sets
// the rate when a byte gives more. A byte's results are registered into the
// queue behind earlier ones; configuration writes are always ready.
module form_urlencoded_field_extract #(
    parameter int KEY_MAX_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  body_byte,
    input  logic        end_of_body,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  item_kind,
    output logic [7:0]  value_byte,
    output logic        final_item
);

    logic [4:0]             key_length_reg;
    logic [63:0]            key_low_reg;
    logic [63:0]            key_high_reg;
    logic [7:0]             value_limit_reg;
    fufe_pkg::parse_state_t state_reg;
    fufe_pkg::parse_state_t state_next;
    fufe_pkg::push_t        push;
    fufe_pkg::result_t      head;
    logic                   in_fire;
    logic                   room;

    assign cfg_ready = 1'b1;
    assign in_ready  = room;
    assign in_fire   = in_valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg  <= 5'd0;
            key_low_reg     <= 64'd0;
            key_high_reg    <= 64'd0;
            value_limit_reg <= 8'd255;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fufe_pkg::REG_KEY_LENGTH:  key_length_reg  <= cfg_data[4:0];
                fufe_pkg::REG_KEY_LOW:     key_low_reg     <= cfg_data;
                fufe_pkg::REG_KEY_HIGH:    key_high_reg    <= cfg_data;
                fufe_pkg::REG_VALUE_LIMIT: value_limit_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{fufe_pkg::PH_NAME, 5'd0, 1'b1, 2'd0, 8'd0, 8'd0};
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    fufe_step #(
        .KEY_MAX_BYTES (KEY_MAX_BYTES)
    ) u_step (
        .state_in       (state_reg),
        .key_length     (key_length_reg),
        .key_bytes_low  (key_low_reg),
        .key_bytes_high (key_high_reg),
        .value_limit    (value_limit_reg),
        .body_byte      (body_byte),
        .end_of_body    (end_of_body),
        .state_out      (state_next),
        .push           (push)
    );

    fufe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (in_fire),
        .push      (push),
        .pop       (out_valid && out_ready),
        .head      (head),
        .not_empty (out_valid),
        .room      (room)
    );

    assign item_kind  = head.kind;
    assign value_byte = head.value;
    assign final_item = head.last;

`ifndef SYNTH
    a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind != fufe_pkg::KIND_VALUE |-> final_item && value_byte == 8'd0)
        else $error("status beat not final or carries data");

    a_value_not_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == fufe_pkg::KIND_VALUE |-> !final_item)
        else $error("value beat marked final");

    a_escape_in_value: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase != fufe_pkg::PH_VALUE |-> state_reg.esc == 2'd0)
        else $error("escape held outside value");

    a_body_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && end_of_body |=>
            state_reg.phase == fufe_pkg::PH_NAME && state_reg.emitted == 8'd0)
        else $error("parse state not cleared at end of body");
`endif

endmodule

### rtl/fufe_step.sv
// Per-byte parse step: next parse state and up to three results for one body byte.
// Depends on fufe_pkg.
module fufe_step #(
    parameter int KEY_MAX_BYTES = 16
) (
    input  fufe_pkg::parse_state_t state_in,
    input  logic [4:0]             key_length,
    input  logic [63:0]            key_bytes_low,
    input  logic [63:0]            key_bytes_high,
    input  logic [7:0]             value_limit,
    input  logic [7:0]             body_byte,
    input  logic                   end_of_body,
    output fufe_pkg::parse_state_t state_out,
    output fufe_pkg::push_t        push
);

    localparam logic [4:0] KEY_MAX_W = 5'(KEY_MAX_BYTES);

    logic [7:0]             key_sel [16];
    fufe_pkg::parse_state_t st;
    fufe_pkg::push_t        pu;
    logic                   finish;
    logic [1:0]             held;
    logic                   vin_emit;
    logic [7:0]             vin_val;
    logic [7:0]             c;

    function automatic fufe_pkg::push_t put(input fufe_pkg::push_t p,
                                            input fufe_pkg::result_t r);
        fufe_pkg::push_t q;
        q = p;
        q.items[p.count] = r;
        q.count = p.count + 2'd1;
        return q;
    endfunction

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            key_sel[i]     = key_bytes_low[8*i +: 8];
            key_sel[i + 8] = key_bytes_high[8*i +: 8];
        end
    end

    always_comb
    begin
        st       = state_in;
        pu       = '0;
        c        = body_byte;
        finish   = 1'b0;
        held     = 2'd0;
        vin_emit = 1'b0;
        vin_val  = 8'd0;
        case (st.phase)
            fufe_pkg::PH_NAME:
            begin
                if (c == fufe_pkg::CH_AMP)
                begin
                    st.name_len   = 5'd0;
                    st.name_match = 1'b1;
                end
                else if (c == fufe_pkg::CH_EQUAL)
                begin
                    if (st.name_match && key_length <= KEY_MAX_W &&
                        st.name_len == key_length)
                    begin
                        st.phase   = fufe_pkg::PH_VALUE;
                        st.esc     = 2'd0;
                        st.emitted = 8'd0;
                    end
                    else
                    begin
                        st.phase = fufe_pkg::PH_SKIP;
                    end
                end
                else
                begin
                    if (st.name_len >= key_length || st.name_len >= KEY_MAX_W ||
                        key_sel[st.name_len[3:0]] != c)
                    begin
                        st.name_match = 1'b0;
                    end
                    if (st.name_len != 5'd31)
                    begin
                        st.name_len = st.name_len + 5'd1;
                    end
                end
            end
            fufe_pkg::PH_SKIP:
            begin
                if (c == fufe_pkg::CH_AMP)
                begin
                    st.phase      = fufe_pkg::PH_NAME;
                    st.name_len   = 5'd0;
                    st.name_match = 1'b1;
                end
            end
            fufe_pkg::PH_VALUE:
            begin
                if (c == fufe_pkg::CH_AMP)
                begin
                    finish   = 1'b1;
                    st.phase = fufe_pkg::PH_DONE;
                end
                else if (st.esc == 2'd0)
                begin
                    if (c == fufe_pkg::CH_PERCENT && st.emitted < value_limit)
                    begin
                        st.esc = 2'd1;
                    end
                    else
                    begin
                        vin_emit = 1'b1;
                        vin_val  = (c == fufe_pkg::CH_PLUS) ? fufe_pkg::CH_SPACE : c;
                    end
                end
                else if (st.esc == 2'd1)
                begin
                    st.hex1 = c;
                    st.esc  = 2'd2;
                end
                else
                begin
                    st.esc   = 2'd0;
                    vin_emit = 1'b1;
                    vin_val  = fufe_pkg::decode_pair(st.hex1, c);
                end
            end
            default:
            begin
            end
        endcase

        if (vin_emit && st.emitted < value_limit)
        begin
            pu         = put(pu, '{fufe_pkg::KIND_VALUE, vin_val, 1'b0});
            st.emitted = st.emitted + 8'd1;
        end

        if (finish || (end_of_body && st.phase == fufe_pkg::PH_VALUE))
        begin
            held   = st.esc;
            st.esc = 2'd0;
            if (held != 2'd0 && st.emitted < value_limit)
            begin
                pu         = put(pu, '{fufe_pkg::KIND_VALUE, fufe_pkg::CH_PERCENT, 1'b0});
                st.emitted = st.emitted + 8'd1;
            end
            if (held == 2'd2 && st.emitted < value_limit)
            begin
                pu = put(pu, '{fufe_pkg::KIND_VALUE,
                               (st.hex1 == fufe_pkg::CH_PLUS) ? fufe_pkg::CH_SPACE : st.hex1,
                               1'b0});
                st.emitted = st.emitted + 8'd1;
            end
            pu = put(pu, '{fufe_pkg::KIND_FOUND, 8'd0, 1'b1});
        end
        else if (end_of_body && st.phase != fufe_pkg::PH_DONE)
        begin
            pu = put(pu, '{fufe_pkg::KIND_NOT_FOUND, 8'd0, 1'b1});
        end

        if (end_of_body)
        begin
            st.phase      = fufe_pkg::PH_NAME;
            st.name_len   = 5'd0;
            st.name_match = 1'b1;
            st.esc        = 2'd0;
            st.hex1       = 8'd0;
            st.emitted    = 8'd0;
        end

        state_out = st;
        push      = pu;
    end

endmodule

### rtl/fufe_queue.sv
// Result queue: takes up to three results per cycle, delivers one per beat.
// Depends on fufe_pkg.
module fufe_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_en,
    input  fufe_pkg::push_t    push,
    input  logic               pop,
    output fufe_pkg::result_t  head,
    output logic               not_empty,
    output logic               room
);

    fufe_pkg::result_t             q_reg [fufe_pkg::QUEUE_DEPTH];
    logic [fufe_pkg::QPTR_W-1:0]   wr_reg;
    logic [fufe_pkg::QPTR_W-1:0]   wr_next;
    logic [fufe_pkg::QPTR_W-1:0]   rd_reg;
    logic [fufe_pkg::QPTR_W-1:0]   rd_next;
    logic [fufe_pkg::QCNT_W-1:0]   count_reg;
    logic [fufe_pkg::QCNT_W-1:0]   count_next;
    logic [1:0]                    n_push;

    assign n_push     = push_en ? push.count : 2'd0;
    assign wr_next    = wr_reg + fufe_pkg::QPTR_W'(n_push);
    assign rd_next    = rd_reg + fufe_pkg::QPTR_W'(pop);
    assign count_next = count_reg + fufe_pkg::QCNT_W'(n_push) - fufe_pkg::QCNT_W'(pop);

    assign head      = q_reg[rd_reg];
    assign not_empty = (count_reg != '0);
    assign room      = (count_reg <= fufe_pkg::QCNT_W'(fufe_pkg::QUEUE_DEPTH - fufe_pkg::MAX_PUSH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < fufe_pkg::MAX_PUSH; i++)
        begin
            if (2'(i) < n_push)
            begin
                q_reg[wr_reg + fufe_pkg::QPTR_W'(i)] <= push.items[i];
            end
        end
    end

endmodule

### tb/sv/form_urlencoded_field_extract_tb.sv
// Self-checking testbench for form_urlencoded_field_extract: drives form bodies and
// register writes, predicts every result beat and compares them as they leave.
// Depends on fufe_pkg and the form_urlencoded_field_extract RTL.
module form_urlencoded_field_extract_tb;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 4;
    localparam int KEY_BYTES       = 16;
    localparam int ITEM_TARGET     = 220;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } body_beat_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [63:0] data;
    } reg_write_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic [2:0]  cfg_index   = '0;
    logic [63:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic [7:0]  body_byte   = '0;
    logic        end_of_body = 1'b0;
    logic        out_ready   = 1'b0;
    logic        cfg_ready;
    logic        in_ready;
    logic        out_valid;
    logic [1:0]  item_kind;
    logic [7:0]  value_byte;
    logic        final_item;

    form_urlencoded_field_extract dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .body_byte  (body_byte),
        .end_of_body(end_of_body),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .item_kind  (item_kind),
        .value_byte (value_byte),
        .final_item (final_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // register copies and parse state of the predictor
    logic [4:0]  want_key_len  = 5'd0;
    logic [63:0] want_key_low  = '0;
    logic [63:0] want_key_high = '0;
    logic [7:0]  want_limit    = 8'd255;
    logic [1:0]  pred_phase     = fufe_pkg::PH_NAME;
    logic [4:0]  pred_name_len  = 5'd0;
    logic        pred_name_ok   = 1'b1;
    logic [1:0]  pred_esc_held  = 2'd0;
    logic [7:0]  pred_esc_first = 8'd0;
    logic [7:0]  pred_emitted   = 8'd0;
    int          pred_step_count;

    fufe_pkg::result_t results_due [$];
    fufe_pkg::result_t oldest_due;
    body_beat_t  bytes_waiting [$];
    body_beat_t  next_beat;
    reg_write_t  reg_writes_due [$];
    reg_write_t  next_write;

    logic [7:0]  cur_key [KEY_BYTES];
    int          cur_key_len;

    int bytes_queued    = 0;
    int bytes_accepted  = 0;
    int bodies_queued   = 0;
    int regs_requested  = 0;
    int regs_written    = 0;
    int beats_checked   = 0;
    int found_count     = 0;
    int not_found_count = 0;
    int failures        = 0;
    int cycle_count     = 0;
    int send_gap_pct    = 0;
    int recv_stall_pct  = 0;
    int hold_left       = 0;
    logic hold_req      = 1'b0;
    logic hold_ack      = 1'b0;

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= fufe_pkg::CH_0 && c <= fufe_pkg::CH_9)
            return int'(c - fufe_pkg::CH_0);
        if (c >= fufe_pkg::CH_LA && c <= fufe_pkg::CH_LF_HEX)
            return int'(c - fufe_pkg::CH_LA) + 10;
        if (c >= fufe_pkg::CH_UA && c <= fufe_pkg::CH_UF_HEX)
            return int'(c - fufe_pkg::CH_UA) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] escape_value(input logic [7:0] hi_char,
                                                input logic [7:0] lo_char);
        int hi_val;
        int lo_val;
        hi_val = hex_digit(hi_char);
        lo_val = hex_digit(lo_char);
        if (hi_val >= 0)
            return 8'(lo_val >= 0 ? hi_val * 16 + lo_val : hi_val);
        if (hi_char == fufe_pkg::CH_SPACE || hi_char == fufe_pkg::CH_PLUS ||
            (hi_char >= fufe_pkg::CH_TAB && hi_char <= fufe_pkg::CH_CR))
            return 8'(lo_val >= 0 ? lo_val : 0);
        if (hi_char == fufe_pkg::CH_MINUS && lo_val >= 0)
            return 8'(256 - lo_val);
        return 8'h00;
    endfunction

    function automatic logic [7:0] key_byte(input logic [4:0] i);
        return (i < 5'd8) ? want_key_low[8*i +: 8] : want_key_high[8*(i-8) +: 8];
    endfunction

    task automatic expect_beat(input logic [1:0] kind, input logic [7:0] value,
                               input logic last);
        fufe_pkg::result_t r;
        if (pred_step_count < fufe_pkg::MAX_PUSH)
        begin
            r.kind  = kind;
            r.value = value;
            r.last  = last;
            results_due.push_back(r);
        end
        pred_step_count++;
    endtask

    task automatic emit_decoded(input logic [7:0] v);
        if (pred_emitted < want_limit)
        begin
            expect_beat(fufe_pkg::KIND_VALUE, v, 1'b0);
            pred_emitted++;
        end
    endtask

    task automatic emit_plain(input logic [7:0] c);
        emit_decoded(c == fufe_pkg::CH_PLUS ? fufe_pkg::CH_SPACE : c);
    endtask

    task automatic take_value_byte(input logic [7:0] c);
        if (pred_esc_held == 2'd0)
        begin
            if (c == fufe_pkg::CH_PERCENT && pred_emitted < want_limit)
                pred_esc_held = 2'd1;
            else
                emit_plain(c);
        end
        else if (pred_esc_held == 2'd1)
        begin
            pred_esc_first = c;
            pred_esc_held  = 2'd2;
        end
        else
        begin
            pred_esc_held = 2'd0;
            emit_decoded(escape_value(pred_esc_first, c));
        end
    endtask

    task automatic flush_escape();
        logic [1:0] held;
        held = pred_esc_held;
        pred_esc_held = 2'd0;
        if (held != 2'd0)
            emit_decoded(fufe_pkg::CH_PERCENT);
        if (held == 2'd2)
            emit_plain(pred_esc_first);
    endtask

    task automatic restart_pair();
        pred_name_len = 5'd0;
        pred_name_ok  = 1'b1;
    endtask

    task automatic advance_parser(input logic [7:0] c, input logic last);
        pred_step_count = 0;
        case (pred_phase)
            fufe_pkg::PH_NAME:
            begin
                if (c == fufe_pkg::CH_AMP)
                    restart_pair();
                else if (c == fufe_pkg::CH_EQUAL)
                begin
                    if (pred_name_ok && want_key_len <= KEY_BYTES &&
                        pred_name_len == want_key_len)
                    begin
                        pred_phase    = fufe_pkg::PH_VALUE;
                        pred_esc_held = 2'd0;
                        pred_emitted  = 8'd0;
                    end
                    else
                        pred_phase = fufe_pkg::PH_SKIP;
                end
                else
                begin
                    if (pred_name_len >= want_key_len || pred_name_len >= KEY_BYTES ||
                        key_byte(pred_name_len) != c)
                        pred_name_ok = 1'b0;
                    if (pred_name_len < 5'd31)
                        pred_name_len++;
                end
            end
            fufe_pkg::PH_SKIP:
            begin
                if (c == fufe_pkg::CH_AMP)
                begin
                    pred_phase = fufe_pkg::PH_NAME;
                    restart_pair();
                end
            end
            fufe_pkg::PH_VALUE:
            begin
                if (c == fufe_pkg::CH_AMP)
                begin
                    flush_escape();
                    expect_beat(fufe_pkg::KIND_FOUND, 8'd0, 1'b1);
                    pred_phase = fufe_pkg::PH_DONE;
                end
                else
                    take_value_byte(c);
            end
            default:
            begin
            end
        endcase
        if (last)
        begin
            if (pred_phase == fufe_pkg::PH_VALUE)
            begin
                flush_escape();
                expect_beat(fufe_pkg::KIND_FOUND, 8'd0, 1'b1);
            end
            else if (pred_phase != fufe_pkg::PH_DONE)
                expect_beat(fufe_pkg::KIND_NOT_FOUND, 8'd0, 1'b1);
            pred_phase     = fufe_pkg::PH_NAME;
            restart_pair();
            pred_esc_held  = 2'd0;
            pred_esc_first = 8'd0;
            pred_emitted   = 8'd0;
        end
    endtask

    task automatic apply_reg(input logic [2:0] index, input logic [63:0] data);
        case (index)
            fufe_pkg::REG_KEY_LENGTH:  want_key_len  = data[4:0];
            fufe_pkg::REG_KEY_LOW:     want_key_low  = data;
            fufe_pkg::REG_KEY_HIGH:    want_key_high = data;
            fufe_pkg::REG_VALUE_LIMIT: want_limit    = data[7:0];
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_reg(cfg_index, cfg_data);
                regs_written++;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_writes_due.size() != 0)
                begin
                    next_write = reg_writes_due.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= next_write.index;
                    cfg_data  <= next_write.data;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            body_byte   <= '0;
            end_of_body <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                advance_parser(body_byte, end_of_body);
                bytes_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (bytes_waiting.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    next_beat = bytes_waiting.pop_front();
                    in_valid    <= 1'b1;
                    body_byte   <= next_beat.data;
                    end_of_body <= next_beat.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_ack  <= 1'b0;
        end
        else if (hold_ack != hold_req)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_OFF_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                beats_checked++;
                if (results_due.size() == 0)
                begin
                    $error("unexpected beat: item_kind %0d value_byte %0h final_item %0b",
                           item_kind, value_byte, final_item);
                    failures++;
                end
                else
                begin
                    oldest_due = results_due.pop_front();
                    if (item_kind !== oldest_due.kind)
                    begin
                        $error("item_kind: expected %0d, got %0d", oldest_due.kind, item_kind);
                        failures++;
                    end
                    if (value_byte !== oldest_due.value)
                    begin
                        $error("value_byte: expected %0h, got %0h", oldest_due.value,
                               value_byte);
                        failures++;
                    end
                    if (final_item !== oldest_due.last)
                    begin
                        $error("final_item: expected %0b, got %0b", oldest_due.last,
                               final_item);
                        failures++;
                    end
                    if (oldest_due.kind == fufe_pkg::KIND_FOUND)
                        found_count++;
                    else if (oldest_due.kind == fufe_pkg::KIND_NOT_FOUND)
                        not_found_count++;
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] data, input logic last);
        body_beat_t b;
        b.data = data;
        b.last = last;
        bytes_waiting.push_back(b);
        bytes_queued++;
        if (last)
            bodies_queued++;
    endtask

    task automatic queue_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_byte(s[i], i == s.len() - 1);
    endtask

    task automatic set_reg(input logic [2:0] index, input logic [63:0] data);
        reg_write_t w;
        w.index = index;
        w.data  = data;
        reg_writes_due.push_back(w);
        regs_requested++;
    endtask

    task automatic commit_regs();
        while (regs_written != regs_requested)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic drain();
        while (bytes_accepted != bytes_queued || results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // fill key bytes past the length with noise so every register bit moves
    task automatic write_key(input int len_value);
        logic [63:0] low_word;
        logic [63:0] high_word;
        int i;
        for (i = 0; i < KEY_BYTES; i++)
        begin
            if (i >= len_value)
                cur_key[i] = 8'($urandom_range(255));
            if (i < 8)
                low_word[8*i +: 8] = cur_key[i];
            else
                high_word[8*(i-8) +: 8] = cur_key[i];
        end
        cur_key_len = len_value;
        set_reg(fufe_pkg::REG_KEY_LENGTH, 64'(len_value));
        set_reg(fufe_pkg::REG_KEY_LOW, low_word);
        set_reg(fufe_pkg::REG_KEY_HIGH, high_word);
    endtask

    function automatic logic [7:0] rand_key_byte();
        logic [7:0] c;
        if ($urandom_range(3) != 0)
            c = 8'($urandom_range(8'h7A, fufe_pkg::CH_LA));
        else
        begin
            c = 8'($urandom_range(255));
            if (c == fufe_pkg::CH_AMP || c == fufe_pkg::CH_EQUAL)
                c = fufe_pkg::CH_PLUS;
        end
        return c;
    endfunction

    function automatic logic [7:0] rand_value_byte();
        string hex_chars;
        hex_chars = "0123456789abcdefABCDEF";
        case ($urandom_range(9))
            0, 1:    return hex_chars[$urandom_range(21)];
            2:       return fufe_pkg::CH_PERCENT;
            3:       return fufe_pkg::CH_PLUS;
            4:       return fufe_pkg::CH_MINUS;
            5:       return $urandom_range(1) ? fufe_pkg::CH_SPACE :
                            8'($urandom_range(fufe_pkg::CH_CR, fufe_pkg::CH_TAB));
            6:       return 8'($urandom_range(255));
            default: return 8'($urandom_range(8'h7A, fufe_pkg::CH_LA));
        endcase
    endfunction

    task automatic queue_random_body();
        logic [7:0] text [$];
        int pairs;
        int kind;
        int len;
        int i;
        int p;
        if ($urandom_range(9) == 0)
        begin
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++)
                text.push_back(8'($urandom_range(255)));
        end
        else
        begin
            pairs = $urandom_range(1, 4);
            for (p = 0; p < pairs; p++)
            begin
                if (p > 0)
                    text.push_back(fufe_pkg::CH_AMP);
                kind = $urandom_range(9);
                if (kind == 8)
                begin
                    len = $urandom_range(0, 6);
                    for (i = 0; i < len; i++)
                        text.push_back(rand_key_byte());
                end
                else
                begin
                    len = cur_key_len;
                    if (kind == 6)
                        len++;
                    if (kind == 5 && len > 0)
                        len--;
                    for (i = 0; i < len; i++)
                        text.push_back(i < cur_key_len ? cur_key[i % KEY_BYTES]
                                                       : rand_key_byte());
                    if (kind == 7 && len > 0)
                        text[text.size() - 1 - $urandom_range(len - 1)] = rand_key_byte();
                end
                if (kind != 9)
                begin
                    text.push_back(fufe_pkg::CH_EQUAL);
                    len = $urandom_range(0, 8);
                    for (i = 0; i < len; i++)
                        text.push_back(rand_value_byte());
                end
            end
            if ($urandom_range(7) == 0)
                text.push_back(fufe_pkg::CH_AMP);
        end
        if (text.size() == 0)
            text.push_back(rand_value_byte());
        for (i = 0; i < text.size(); i++)
            queue_byte(text[i], i == text.size() - 1);
    endtask

    task automatic pick_config();
        int len;
        int i;
        case ($urandom_range(7))
            0:       len = 0;
            1:       len = KEY_BYTES;
            2:       len = $urandom_range(31, 17);
            default: len = $urandom_range(1, 5);
        endcase
        for (i = 0; i < KEY_BYTES; i++)
            cur_key[i] = rand_key_byte();
        write_key(len);
        case ($urandom_range(5))
            0:       set_reg(fufe_pkg::REG_VALUE_LIMIT, 64'd0);
            1:       set_reg(fufe_pkg::REG_VALUE_LIMIT, 64'd1);
            2:       set_reg(fufe_pkg::REG_VALUE_LIMIT, 64'd255);
            default: set_reg(fufe_pkg::REG_VALUE_LIMIT, 64'($urandom_range(2, 8)));
        endcase
        commit_regs();
    endtask

    initial
    begin
        int gap_by_mode [4];
        int stall_by_mode [4];
        int seg;
        int start;
        int i;
        gap_by_mode   = '{0, 48, 0, 25};
        stall_by_mode = '{0, 0, 48, 25};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty key out of reset matches a pair that starts with '='
        queue_text("=q");
        drain();

        cur_key[0] = "a";
        cur_key[1] = "b";
        write_key(2);
        set_reg(fufe_pkg::REG_VALUE_LIMIT, 64'd255);
        commit_regs();
        queue_text("ab=+%41%4g%zz&z");
        queue_text("ab&ab=% 5%-f%+a%");
        queue_text("ab=%+");
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        drain();

        set_reg(fufe_pkg::REG_VALUE_LIMIT, 64'd2);
        commit_regs();
        queue_text("ab=wxyz%41");
        drain();

        set_reg(fufe_pkg::REG_VALUE_LIMIT, 64'd0);
        commit_regs();
        queue_text("ab=%4");
        drain();

        for (i = 0; i < KEY_BYTES; i++)
            cur_key[i] = rand_key_byte();
        write_key(KEY_BYTES);
        set_reg(fufe_pkg::REG_VALUE_LIMIT, 64'd255);
        commit_regs();
        for (i = 0; i < KEY_BYTES; i++)
            queue_byte(cur_key[i], 1'b0);
        queue_text("=v");
        drain();

        write_key(31);
        commit_regs();
        queue_text("=v");
        drain();

        start = bytes_queued;
        for (seg = 0; seg < 8; seg++)
        begin
            send_gap_pct   <= gap_by_mode[seg / 2];
            recv_stall_pct <= stall_by_mode[seg / 2];
            pick_config();
            do
                queue_random_body();
            while (bytes_queued - start < (ITEM_TARGET - start) * (seg + 1) / 8);
            if (seg == 0)
                hold_req <= ~hold_req;
            drain();
        end

        send_gap_pct   <= 0;
        recv_stall_pct <= 0;
        drain();
        repeat (8) @(posedge clk);
        $display("Covered %0d body bytes in %0d bodies with %0d register writes,",
                 bytes_accepted, bodies_queued, regs_written);
        $display("%0d result beats checked; key found %0d times and missing %0d times.",
                 beats_checked, found_count, not_found_count);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
